>>> src/frt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frt_pkg
// shared types and codes for the fragment reassembly tracker
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int POS_W  = 12;
  localparam int ID_W   = 16;
  localparam int OFF_W  = 11;
  localparam int DATA_W = 8;

  // input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BEYOND   = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    logic             v;
  } range_t;

  typedef enum logic [1:0] {
    PH_HOLD,
    PH_MERGE,
    PH_PLACE,
    PH_COMPACT
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   clear;
    range_t probe;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MERGE,
    ST_PLACE,
    ST_COMPACT,
    ST_FINISH
  } state_t;

endpackage : frt_pkg
`default_nettype wire

>>> src/frt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frt_cell
// one entry of the range list with its wavefront carry register
// ----------------------------------------------------------------------------
module frt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire frt_pkg::cell_ctl_t ctl,
  input  wire frt_pkg::range_t   carry_in,
  output frt_pkg::range_t        carry_out,
  input  wire frt_pkg::range_t   right_in,
  input  wire logic              pre_in,
  output logic                   pre_out,
  output frt_pkg::range_t        ent_out,
  output logic                   hit
);

  frt_pkg::range_t ent_r, ent_nxt;
  frt_pkg::range_t car_r, car_nxt;

  assign pre_out   = pre_in | ~ent_r.v;
  assign ent_out   = ent_r;
  assign carry_out = car_r;
  assign hit = ent_r.v && (ent_r.s <= ctl.probe.e) && (ent_r.e >= ctl.probe.s);

  always_comb begin
    ent_nxt = ent_r;
    car_nxt = carry_in;
    unique case (ctl.phase)
      frt_pkg::PH_MERGE: begin
        // absorb an overlapping or touching entry into the carry
        if (carry_in.v && ent_r.v && (ent_r.s <= carry_in.e) && (ent_r.e >= carry_in.s)) begin
          ent_nxt.v = 1'b0;
          car_nxt.s = (ent_r.s < carry_in.s) ? ent_r.s : carry_in.s;
          car_nxt.e = (ent_r.e > carry_in.e) ? ent_r.e : carry_in.e;
        end
      end
      frt_pkg::PH_PLACE: begin
        if (carry_in.v) begin
          if (!ent_r.v) begin
            ent_nxt   = carry_in;
            car_nxt.v = 1'b0;
          end else if (ent_r.e >= carry_in.s) begin
            // entry lies after the carry: swap and push it right
            ent_nxt = carry_in;
            car_nxt = ent_r;
          end
        end
      end
      frt_pkg::PH_COMPACT: begin
        if (pre_out) begin
          ent_nxt = right_in;
        end
      end
      frt_pkg::PH_HOLD: begin
      end
      default: begin
      end
    endcase
    if (ctl.clear) begin
      ent_nxt.v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.v <= 1'b0;
      car_r.v <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
      car_r <= car_nxt;
    end
  end

endmodule : frt_cell
`default_nettype wire

>>> src/frt_payload_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frt_payload_mem
// payload byte buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module frt_payload_mem #(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [frt_pkg::DATA_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [frt_pkg::DATA_W-1:0]  rd_data
);

  logic [frt_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : frt_payload_mem
`default_nettype wire

>>> src/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// byte buffer plus a sorted, merged range list kept in a row of cells
// ----------------------------------------------------------------------------
// payload bytes and reads are taken one per cycle while busy is low; a read
// result shows in the cycle after it is taken.
// a fragment's last byte keeps the block busy through check, merge wave, place
// wave, compaction and finish; its status shows in the cycle after finish.
// a fragment rejected in the check (beyond packet or buffer, or list full, no entry
// touched) goes back to idle; its status shows in the cycle after the check.
// the result port cannot be stalled: out_valid marks a result for one cycle.
// synchronous active-low reset empties the range list and clears packet id
// and size; buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
  parameter int BUF_BYTES  = 2048,
  parameter int MAX_RANGES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_cmd,
  input  wire logic [frt_pkg::ID_W-1:0]     in_packet_id,
  input  wire logic [frt_pkg::POS_W-1:0]    in_packet_size,
  input  wire logic [frt_pkg::OFF_W-1:0]    in_frag_offset,
  input  wire logic [frt_pkg::POS_W-1:0]    in_frag_length,
  input  wire logic [frt_pkg::OFF_W-1:0]    in_byte_pos,
  input  wire logic [frt_pkg::DATA_W-1:0]   in_data_byte,
  input  wire logic                         in_last_of_fragment,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic                              out_packet_complete,
  output logic      [frt_pkg::DATA_W-1:0]   out_read_byte,
  output logic      [1:0]                   out_status
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(MAX_RANGES);
  localparam int EW = frt_pkg::POS_W + 1;

  // control state
  frt_pkg::state_t st_r, st_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [frt_pkg::ID_W-1:0]  pid_r;
  logic [frt_pkg::POS_W-1:0] esize_r;
  logic [frt_pkg::POS_W-1:0] b_r;      // fragment start
  logic [EW-1:0]             e_r;      // fragment end, one bit wider for the range check

  // result registers
  logic                      out_valid_r;
  logic                      out_kind_r;
  logic                      out_cpl_r;
  logic [1:0]                out_status_r;
  logic                      rd_ok_r;
  logic [frt_pkg::DATA_W-1:0] rd_q;

  // cell row wiring
  frt_pkg::cell_ctl_t ctl;
  frt_pkg::range_t    car_head;
  frt_pkg::range_t    ent  [MAX_RANGES];
  frt_pkg::range_t    car  [MAX_RANGES+1];
  logic               pre  [MAX_RANGES+1];
  logic [MAX_RANGES-1:0] hit;

  logic accept, acc_wr, acc_rd, new_pkt;
  logic [frt_pkg::POS_W-1:0] wr_addr;
  logic wr_en;
  logic [EW-1:0] frag_end;
  logic bad_range, full, ovf, cnt_last, complete_now;
  logic load_status, load_read;
  logic [1:0] status_val;

  assign accept = start && !busy;
  assign acc_wr = accept && (in_cmd == frt_pkg::CMD_WRITE);
  assign acc_rd = accept && (in_cmd == frt_pkg::CMD_READ);
  // any id or size change starts a new packet
  assign new_pkt = acc_wr && ((in_packet_id != pid_r) || (in_packet_size != esize_r));

  // payload write: byte must land inside the packet and the buffer
  assign wr_addr = {1'b0, in_frag_offset} + {1'b0, in_byte_pos};
  assign wr_en   = acc_wr && (wr_addr < in_packet_size)
                   && ({20'd0, wr_addr} < 32'(BUF_BYTES));
  assign frag_end = {2'b00, in_frag_offset} + {1'b0, in_frag_length};

  frt_payload_mem #(
    .DEPTH (BUF_BYTES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(wr_addr)),
    .wr_data (in_data_byte),
    .rd_en   (acc_rd),
    .rd_addr (AW'(in_byte_pos)),
    .rd_data (rd_q)
  );

  // header tracking and fragment capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_r   <= '0;
      esize_r <= '0;
    end else if (new_pkt) begin
      pid_r   <= in_packet_id;
      esize_r <= in_packet_size;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_wr && in_last_of_fragment) begin
      b_r <= {1'b0, in_frag_offset};
      e_r <= frag_end;
    end
  end

  // fragment checks, evaluated in the check state against the list as it stands
  assign bad_range = (e_r > {1'b0, esize_r}) || ({19'd0, e_r} > 32'(BUF_BYTES));
  assign full      = ent[MAX_RANGES-1].v;
  assign ovf       = full && !(|hit);
  assign cnt_last  = (cnt_r == CW'(MAX_RANGES - 1));

  // the list is kept sorted and separated, so complete means one range 0..size
  assign complete_now = ent[0].v && (ent[0].s == '0) && (ent[0].e == esize_r) && !ent[1].v;

  // row of cells: carry wave runs left to right, compaction pulls right to left
  assign pre[0] = 1'b0;
  assign car[0] = car_head;
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    frt_pkg::range_t right;
    if (i == MAX_RANGES - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = ent[i+1];
    end
    frt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .carry_in  (car[i]),
      .carry_out (car[i+1]),
      .right_in  (right),
      .pre_in    (pre[i]),
      .pre_out   (pre[i+1]),
      .ent_out   (ent[i]),
      .hit       (hit[i])
    );
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      frt_pkg::ST_IDLE: begin
        if (acc_wr && in_last_of_fragment) begin
          st_nxt = frt_pkg::ST_CHECK;
        end
      end
      frt_pkg::ST_CHECK: begin
        cnt_nxt = '0;
        st_nxt  = (bad_range || ovf) ? frt_pkg::ST_IDLE : frt_pkg::ST_MERGE;
      end
      frt_pkg::ST_MERGE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt = '0;
          st_nxt  = frt_pkg::ST_PLACE;
        end
      end
      frt_pkg::ST_PLACE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt = '0;
          st_nxt  = frt_pkg::ST_COMPACT;
        end
      end
      frt_pkg::ST_COMPACT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt = '0;
          st_nxt  = frt_pkg::ST_FINISH;
        end
      end
      frt_pkg::ST_FINISH: begin
        st_nxt = frt_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = frt_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    busy        = (st_r != frt_pkg::ST_IDLE);
    ctl.phase   = frt_pkg::PH_HOLD;
    ctl.clear   = new_pkt;
    ctl.probe   = '{s: b_r, e: e_r[frt_pkg::POS_W-1:0], v: 1'b1};
    car_head    = '0;
    load_status = 1'b0;
    load_read   = acc_rd;
    status_val  = frt_pkg::STAT_OK;
    unique case (st_r)
      frt_pkg::ST_IDLE: begin
      end
      frt_pkg::ST_CHECK: begin
        if (bad_range) begin
          load_status = 1'b1;
          status_val  = frt_pkg::STAT_BEYOND;
        end else if (ovf) begin
          load_status = 1'b1;
          status_val  = frt_pkg::STAT_OVERFLOW;
        end
      end
      frt_pkg::ST_MERGE: begin
        ctl.phase = frt_pkg::PH_MERGE;
        if (cnt_r == '0) begin
          car_head = '{s: b_r, e: e_r[frt_pkg::POS_W-1:0], v: 1'b1};
        end
      end
      frt_pkg::ST_PLACE: begin
        ctl.phase = frt_pkg::PH_PLACE;
        // merged range leaves the tail of the merge wave right now
        if (cnt_r == '0) begin
          car_head = car[MAX_RANGES];
        end
      end
      frt_pkg::ST_COMPACT: begin
        ctl.phase = frt_pkg::PH_COMPACT;
      end
      frt_pkg::ST_FINISH: begin
        load_status = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= frt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= load_status || load_read;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status || load_read) begin
      out_kind_r   <= load_read ? frt_pkg::KIND_READ : frt_pkg::KIND_STATUS;
      out_cpl_r    <= complete_now;
      out_status_r <= status_val;
      rd_ok_r      <= load_read && ({21'd0, in_byte_pos} < 32'(BUF_BYTES));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_packet_complete = out_cpl_r;
  assign out_status          = out_status_r;
  assign out_read_byte       = (out_kind_r == frt_pkg::KIND_READ && rd_ok_r) ? rd_q : '0;

  // checks
  a_read_has_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == frt_pkg::KIND_READ) |-> (out_status == frt_pkg::STAT_OK))
    else $error("read result carries a status code");

  a_check_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == frt_pkg::ST_CHECK) |-> $past(acc_wr && in_last_of_fragment))
    else $error("check state entered without a last fragment byte");

  a_merged_range_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == frt_pkg::ST_PLACE) && (cnt_r == '0) |-> car[MAX_RANGES].v)
    else $error("merge wave did not deliver a range");

  a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == frt_pkg::STAT_OVERFLOW) |-> ent[MAX_RANGES-1].v)
    else $error("overflow reported with room in the list");

endmodule : fragment_reassembly_tracker
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fragment reassembly tracker
// ----------------------------------------------------------------------------
// a class-based scoreboard keeps its own copy of the range list, packet id and
// size and a shadow of the payload buffer. it predicts read results and the
// status of each fragment's last byte. random reads only touch bytes that have been
// written. stimulus is a directed prologue, then random fragmented packets
// with random content, mixed with noise and broken fragments.
// ----------------------------------------------------------------------------

class reassembly_scoreboard;
  localparam int NBUF = 2048;
  localparam int NRNG = 16;

  typedef struct {
    logic       kind;
    logic       complete;
    logic [7:0] rbyte;
    logic [1:0] status;
  } result_t;

  logic [7:0]  buf_mem [NBUF];
  bit          written [NBUF];
  int unsigned rs [NRNG];
  int unsigned re [NRNG];
  int unsigned nr;
  int unsigned cur_id;
  int unsigned cur_size;
  result_t     pending [$];
  int          errors;

  function new();
    nr = 0;
    cur_id = 0;
    cur_size = 0;
    errors = 0;
  endfunction

  function bit covered();
    int unsigned last;
    last = 0;
    if (nr == 0) return 0;
    if (re[nr-1] != cur_size || rs[0] != 0) return 0;
    for (int i = 0; i < nr; i++) begin
      if (rs[i] > last) return 0;
      last = re[i];
    end
    return 1;
  endfunction

  // sorted insert with ties after equal starts, then merge of touching ranges
  function logic [1:0] add_range(int unsigned b, int unsigned e);
    int unsigned ts [NRNG+1];
    int unsigned te [NRNG+1];
    int unsigned ms [NRNG+1];
    int unsigned me [NRNG+1];
    int unsigned p, k, m;
    p = nr;
    k = 0;
    m = 0;
    for (int i = 0; i < nr; i++)
      if (b < rs[i]) begin
        p = i;
        break;
      end
    for (int i = 0; i <= nr; i++) begin
      if (i == p) begin
        ts[i] = b;
        te[i] = e;
      end else begin
        ts[i] = rs[k];
        te[i] = re[k];
        k++;
      end
    end
    for (int i = 0; i <= nr; i++) begin
      if (m > 0 && me[m-1] >= ts[i]) begin
        if (te[i] > me[m-1]) me[m-1] = te[i];
      end else begin
        ms[m] = ts[i];
        me[m] = te[i];
        m++;
      end
    end
    if (m > NRNG) return frt_pkg::STAT_OVERFLOW;
    for (int i = 0; i < m; i++) begin
      rs[i] = ms[i];
      re[i] = me[i];
    end
    nr = m;
    return frt_pkg::STAT_OK;
  endfunction

  function void note_item(logic cmd, int unsigned pid, int unsigned psize, int unsigned off,
                          int unsigned len, int unsigned bpos, logic [7:0] d, logic last);
    result_t r;
    int unsigned addr;
    if (cmd == frt_pkg::CMD_READ) begin
      r.kind = frt_pkg::KIND_READ;
      r.complete = covered();
      r.rbyte = (bpos < NBUF) ? buf_mem[bpos] : 8'd0;
      r.status = frt_pkg::STAT_OK;
      pending = {pending, r};
      return;
    end
    if (pid != cur_id || psize != cur_size) begin
      cur_id = pid;
      cur_size = psize;
      nr = 0;
    end
    addr = off + bpos;
    if (addr < cur_size && addr < NBUF) begin
      buf_mem[addr] = d;
      written[addr] = 1;
    end
    if (!last) return;
    r.kind = frt_pkg::KIND_STATUS;
    r.rbyte = 8'd0;
    if (off + len > cur_size || off + len > NBUF) r.status = frt_pkg::STAT_BEYOND;
    else r.status = add_range(off, off + len);
    r.complete = covered();
    pending = {pending, r};
  endfunction

  function void check_result(logic kind, logic complete, logic [7:0] rbyte, logic [1:0] st);
    result_t x;
    if (pending.size() == 0) begin
      $display("%0t unexpected result kind=%0d", $time, kind);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (kind !== x.kind) begin
      $display("%0t kind exp %0d got %0d", $time, x.kind, kind);
      errors++;
    end
    if (complete !== x.complete) begin
      $display("%0t complete exp %0d got %0d", $time, x.complete, complete);
      errors++;
    end
    if (rbyte !== x.rbyte) begin
      $display("%0t read_byte exp %0h got %0h", $time, x.rbyte, rbyte);
      errors++;
    end
    if (st !== x.status) begin
      $display("%0t status exp %0d got %0d", $time, x.status, st);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = frt_pkg::CMD_WRITE;
  logic [frt_pkg::ID_W-1:0] in_packet_id = '0;
  logic [frt_pkg::POS_W-1:0] in_packet_size = '0;
  logic [frt_pkg::OFF_W-1:0] in_frag_offset = '0;
  logic [frt_pkg::POS_W-1:0] in_frag_length = '0;
  logic [frt_pkg::OFF_W-1:0] in_byte_pos = '0;
  logic [frt_pkg::DATA_W-1:0] in_data_byte = '0;
  logic in_last_of_fragment = 1'b0;
  logic out_valid, out_kind, out_packet_complete;
  logic [frt_pkg::DATA_W-1:0] out_read_byte;
  logic [1:0] out_status;

  reassembly_scoreboard sb;
  int idle_pct;
  int items_sent;
  int stall_cycles;

  always #5 clk = ~clk;

  fragment_reassembly_tracker u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_packet_id(in_packet_id), .in_packet_size(in_packet_size),
    .in_frag_offset(in_frag_offset), .in_frag_length(in_frag_length),
    .in_byte_pos(in_byte_pos), .in_data_byte(in_data_byte),
    .in_last_of_fragment(in_last_of_fragment),
    .out_valid(out_valid), .out_kind(out_kind), .out_packet_complete(out_packet_complete),
    .out_read_byte(out_read_byte), .out_status(out_status)
  );

  // results cannot be held off, so every strobe is checked at its edge
  always @(posedge clk)
    if (rst_n && out_valid)
      sb.check_result(out_kind, out_packet_complete, out_read_byte, out_status);

  // watchdog: counts cycles in which nothing is taken and no result appears
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("fragment_reassembly_tracker: mismatch");
      $finish;
    end
  end

  // one item: optional random gap, then hold start until the block takes it
  task automatic send_item(logic cmd, int unsigned pid, int unsigned psize,
                           int unsigned off, int unsigned len, int unsigned bpos,
                           logic [7:0] d, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_packet_id <= pid[frt_pkg::ID_W-1:0];
    in_packet_size <= psize[frt_pkg::POS_W-1:0];
    in_frag_offset <= off[frt_pkg::OFF_W-1:0];
    in_frag_length <= len[frt_pkg::POS_W-1:0];
    in_byte_pos <= bpos[frt_pkg::OFF_W-1:0];
    in_data_byte <= d;
    in_last_of_fragment <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd, pid, psize, off, len, bpos, d, last);
    items_sent++;
  endtask

  // a fragment's bytes; nbytes may differ from len to break the sequence
  task automatic send_fragment(int unsigned pid, int unsigned psize, int unsigned off,
                               int unsigned len, int unsigned nbytes);
    if (nbytes == 0) nbytes = 1;
    for (int i = 0; i < nbytes; i++)
      send_item(frt_pkg::CMD_WRITE, pid, psize, off, len, i, 8'($urandom_range(255)),
                i == nbytes - 1);
  endtask

  // read a byte that has been written, if one is found
  task automatic send_read();
    int unsigned a;
    a = $urandom_range(2047);
    for (int t = 0; t < 64 && !sb.written[a]; t++) a = $urandom_range(2047);
    if (sb.written[a])
      send_item(frt_pkg::CMD_READ, $urandom_range(16'hffff), $urandom_range(4095),
                $urandom_range(2047), $urandom_range(4095), a, 8'($urandom_range(255)),
                1'($urandom_range(1)));
  endtask

  // one packet split into fragments in shuffled order, some duplicated
  task automatic send_packet(int unsigned pid, int unsigned psize);
    int unsigned offs [$];
    int unsigned lens [$];
    int unsigned o, l, j;
    o = 0;
    while (o < psize) begin
      l = $urandom_range(1, (psize - o < 6) ? psize - o : 6);
      offs = {offs, o};
      lens = {lens, l};
      o += l;
    end
    for (int i = offs.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      o = offs[i]; offs[i] = offs[j]; offs[j] = o;
      l = lens[i]; lens[i] = lens[j]; lens[j] = l;
    end
    foreach (offs[i]) begin
      send_fragment(pid, psize, offs[i], lens[i], lens[i]);
      if ($urandom_range(7) == 0) send_fragment(pid, psize, offs[i], lens[i], lens[i]);
      if ($urandom_range(5) == 0) send_read();
    end
    send_read();
  endtask

  // sends about n items
  task automatic run_random(int n);
    int unsigned r, pid, psz;
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      pid = $urandom_range(16'hffff);
      psz = ($urandom_range(19) == 0 && target - items_sent > 400) ?
            $urandom_range(41, 300) : $urandom_range(1, 40);
      if (r < 60) begin
        send_packet(pid, psz);
      end else if (r < 75) begin
        // many disjoint ranges under one id to push toward overflow
        for (int i = 0; i < 20; i++)
          send_fragment(7, 200, i * 10 + $urandom_range(3), $urandom_range(4), 1);
      end else if (r < 90) begin
        // broken fragments: current id and size, random offset and length, possibly past the packet
        send_fragment(sb.cur_id, sb.cur_size, $urandom_range(2047), $urandom_range(4095),
                      $urandom_range(1, 3));
      end else begin
        send_item(frt_pkg::CMD_WRITE, pid, $urandom_range(4095), $urandom_range(2047),
                  $urandom_range(4095), $urandom_range(2047), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  task automatic drain();
    int k;
    k = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && k < 1000) begin
      @(posedge clk);
      k++;
    end
    repeat (3 * 16 + 8) @(posedge clk);
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full-size packet edge, zero-length and empty cases, beyond, reads
    send_fragment(0, 0, 0, 0, 1);
    send_fragment(16'hffff, 2048, 2040, 8, 2);
    send_fragment(16'hffff, 2048, 0, 2048, 2);
    send_item(frt_pkg::CMD_READ, 0, 0, 0, 0, 0, 8'hff, 1'b0);
    send_fragment(16'hffff, 2048, 2047, 2048, 1);
    send_fragment(5, 12, 4, 4, 4);
    send_fragment(5, 12, 4, 0, 1);
    send_fragment(5, 12, 8, 4, 1);
    send_fragment(5, 12, 0, 4, 1);
    send_item(frt_pkg::CMD_READ, 0, 0, 0, 0, 5, 8'h00, 1'b1);
    send_fragment(5, 12, 10, 3, 1);
    send_fragment(6, 12, 11, 1, 3);
    drain();

    idle_pct = 30;
    run_random(620);
    drain();
    idle_pct = 87;
    run_random(620);
    drain();
    idle_pct = 0;
    run_random(620);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("fragment_reassembly_tracker: match");
    else
      $display("fragment_reassembly_tracker: mismatch");
    $finish;
  end
endmodule

>>> files.f
src/frt_pkg.sv
src/frt_cell.sv
src/frt_payload_mem.sv
src/fragment_reassembly_tracker.sv
tb/tb.sv
